[design/mlfcd_pkg.sv]
// shared types and constants of the magic/length frame command decoder
// no dependencies; imported by mlfcd_parser and the top level

package mlfcd_pkg;

    // configuration register indexes
    localparam logic CFG_IDX_MAGIC   = 1'b0;
    localparam logic CFG_IDX_MAX_LEN = 1'b1;

    // configuration reset values
    localparam logic [7:0] MAGIC_RESET   = 8'h42;
    localparam logic [7:0] MAX_LEN_RESET = 8'd20;

    // kinds of decoded command
    localparam logic KIND_FILL  = 1'b0;
    localparam logic KIND_PIXEL = 1'b1;

    // opcodes and the shortest frame that carries each command
    localparam logic [7:0] OP_FILL       = 8'd1;
    localparam logic [7:0] OP_PIXEL      = 8'd2;
    localparam logic [7:0] FILL_MIN_LEN  = 8'd4;
    localparam logic [7:0] PIXEL_MIN_LEN = 8'd6;

    // number of payload bytes kept for decoding
    localparam int HEAD_DEPTH = 6;
    localparam int HEAD_IDX_W = $clog2(HEAD_DEPTH);

    typedef struct packed {
        logic [7:0] magic_byte;
        logic [7:0] max_frame_length;
    } cfg_t;

    typedef struct packed {
        logic       command_kind;
        logic [7:0] pixel_x;
        logic [7:0] pixel_y;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } result_t;

endpackage

[design/mlfcd_parser.sv]
// frame parser: hunt for magic, take length, collect payload, decode command
// depends on mlfcd_pkg

module mlfcd_parser
    import mlfcd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic       cmd,
    input  logic [7:0] rx_byte,
    input  cfg_t       cfg,
    output logic       res_valid,
    output result_t    res
);

    localparam logic [1:0] PHASE_HUNT   = 2'd0;
    localparam logic [1:0] PHASE_LENGTH = 2'd1;
    localparam logic [1:0] PHASE_COPY   = 2'd2;

    logic [1:0] phase_reg, phase_next;
    logic [7:0] frame_length_reg, frame_length_next;
    logic [7:0] byte_index_reg, byte_index_next;
    logic [7:0] head_reg [HEAD_DEPTH];
    logic [7:0] head_view [HEAD_DEPTH];
    logic       head_write;
    logic [7:0] index_inc;

    assign head_write = step && !cmd && (phase_reg == PHASE_COPY)
                        && (byte_index_reg < 8'(HEAD_DEPTH));
    assign index_inc  = byte_index_reg + 8'd1;

    // head as it looks with the current byte already stored
    always_comb
    begin
        for (int i = 0; i < HEAD_DEPTH; i++)
        begin
            head_view[i] = head_reg[i];
        end
        if (head_write)
        begin
            head_view[byte_index_reg[HEAD_IDX_W-1:0]] = rx_byte;
        end
    end

    always_comb
    begin
        phase_next        = phase_reg;
        frame_length_next = frame_length_reg;
        byte_index_next   = byte_index_reg;
        res_valid         = 1'b0;
        res               = '0;
        if (step)
        begin
            if (cmd)
            begin
                phase_next = PHASE_HUNT;
            end
            else
            begin
                case (phase_reg)
                    PHASE_LENGTH:
                    begin
                        if (rx_byte == 8'd0 || rx_byte > cfg.max_frame_length)
                        begin
                            phase_next = PHASE_HUNT;
                        end
                        else
                        begin
                            frame_length_next = rx_byte;
                            byte_index_next   = 8'd0;
                            phase_next        = PHASE_COPY;
                        end
                    end
                    PHASE_COPY:
                    begin
                        byte_index_next = index_inc;
                        if (index_inc == frame_length_reg)
                        begin
                            phase_next = PHASE_HUNT;
                            if (head_view[0] == OP_FILL && frame_length_reg >= FILL_MIN_LEN)
                            begin
                                res_valid        = 1'b1;
                                res.command_kind = KIND_FILL;
                                res.red          = head_view[1];
                                res.green        = head_view[2];
                                res.blue         = head_view[3];
                            end
                            else if (head_view[0] == OP_PIXEL
                                     && frame_length_reg >= PIXEL_MIN_LEN)
                            begin
                                res_valid        = 1'b1;
                                res.command_kind = KIND_PIXEL;
                                res.pixel_x      = head_view[1];
                                res.pixel_y      = head_view[2];
                                res.red          = head_view[3];
                                res.green        = head_view[4];
                                res.blue         = head_view[5];
                            end
                        end
                    end
                    default:
                    begin
                        // hunting, and the unused code
                        if (rx_byte == cfg.magic_byte)
                        begin
                            phase_next = PHASE_LENGTH;
                        end
                        else
                        begin
                            phase_next = PHASE_HUNT;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PHASE_HUNT;
            frame_length_reg <= 8'd0;
            byte_index_reg   <= 8'd0;
        end
        else
        begin
            phase_reg        <= phase_next;
            frame_length_reg <= frame_length_next;
            byte_index_reg   <= byte_index_next;
        end
    end

    // payload head, no reset: decode only reads bytes of the current frame
    always_ff @(posedge clk)
    begin
        if (head_write)
        begin
            head_reg[byte_index_reg[HEAD_IDX_W-1:0]] <= rx_byte;
        end
    end

endmodule

[design/magic_length_frame_command_decoder_top.sv]
// top level of the magic/length frame command decoder
// depends on mlfcd_pkg and mlfcd_parser
//
// channel   | direction | signals                        | content
// ----------+-----------+--------------------------------+-------------------------------
// s_axis    | in        | tvalid tready tdata tuser      | received byte or link error
// m_axis    | out       | tvalid tready tdata tuser      | fill or set-pixel command
// cfg       | in        | cfg_we cfg_addr cfg_wdata      | magic byte, max frame length
//
// one beat accepted per cycle while m_axis does not stall; a command is offered on m_axis
// once the beat completing its frame has passed the input register and then the result
// register, where it waits for the output handshake
// reset puts the parser into hunting for the magic byte, magic 0x42, max length 20
// a stalled result holds in the result register while the input register still
// takes one more beat; s_axis_tready drops only when both are full

module magic_length_frame_command_decoder_top
    import mlfcd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration write port
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [7:0]  cfg_wdata,
    // received stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  logic        s_axis_tuser,   // [0] cmd (1 = link error)
    // command stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [7:0] pixel_x, [15:8] pixel_y, [23:16] red,
                                        // [31:24] green, [39:32] blue
    output logic        m_axis_tuser    // [0] command_kind (1 = set pixel)
);

    cfg_t       cfg_reg;

    // input register
    logic       in_valid_reg;
    logic       in_cmd_reg;
    logic [7:0] in_byte_reg;

    // result register
    logic       out_valid_reg;
    result_t    out_reg;

    logic       advance;
    logic       s_accept;
    logic       res_valid;
    result_t    res;

    // the parser steps when the result register can take whatever it yields
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.magic_byte       <= MAGIC_RESET;
            cfg_reg.max_frame_length <= MAX_LEN_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_IDX_MAGIC:   cfg_reg.magic_byte       <= cfg_wdata;
                CFG_IDX_MAX_LEN: cfg_reg.max_frame_length <= cfg_wdata;
                default:         cfg_reg                  <= cfg_reg;
            endcase
        end
    end

    // input register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_accept)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    // input register payload
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_cmd_reg  <= s_axis_tuser;
            in_byte_reg <= s_axis_tdata;
        end
    end

    mlfcd_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .cmd       (in_cmd_reg),
        .rx_byte   (in_byte_reg),
        .cfg       (cfg_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    // result register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= res_valid;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // result register payload
    always_ff @(posedge clk)
    begin
        if (advance && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_reg.command_kind;
    assign m_axis_tdata  = {out_reg.blue, out_reg.green, out_reg.red,
                            out_reg.pixel_y, out_reg.pixel_x};

    // a command only ever follows a parser step
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(advance))
        else $error("command appeared without a parser step");

    // a link error beat never yields a command
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_cmd_reg) |=> !out_valid_reg)
        else $error("link error produced a command");

    // fill commands carry no coordinates
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.command_kind == KIND_FILL)
            |-> (out_reg.pixel_x == 8'd0 && out_reg.pixel_y == 8'd0))
        else $error("fill command with nonzero coordinates");

endmodule
